>>> hdl/lzwve_pkg.sv
// ---------------------------------------------------------------------------
// LZW encoder package
// Shared constants and the sequencer state type for the LZW encoder.
// ---------------------------------------------------------------------------
`default_nettype none
package lzwve_pkg;
    localparam int TABLE_ENTRIES_DEF = 35023;
    localparam int MAX_CODE_BITS_DEF = 15;
    localparam int CODE_BITS         = 15;
    localparam int WIDTH_BITS        = 4;
    localparam logic [CODE_BITS-1:0] CODE_END   = 15'd256;
    localparam logic [CODE_BITS-1:0] CODE_BUMP  = 15'd257;
    localparam logic [CODE_BITS-1:0] CODE_FLUSH = 15'd258;
    localparam logic [15:0] CODE_FIRST  = 16'd259;
    localparam logic [WIDTH_BITS-1:0] WIDTH_START = 4'd9;
    localparam logic [15:0] BUMP_START  = 16'd511;

    typedef enum logic [8:0] {
        ST_CLEAR = 9'b000000001,
        ST_IDLE  = 9'b000000010,
        ST_HASH  = 9'b000000100,
        ST_READ  = 9'b000001000,
        ST_CHECK = 9'b000010000,
        ST_STEP  = 9'b000100000,
        ST_EMIT0 = 9'b001000000,
        ST_EMIT1 = 9'b010000000,
        ST_WRITE = 9'b100000000
    } state_t;
endpackage
`default_nettype wire

>>> hdl/lzw_variable_width_encoder.sv
// While a data byte is processed s_ready stays low through the hash, step, RAM read
// and compare states; each further probe repeats step, read and compare, and a miss
// adds the write and emit states. No new byte is taken before the last one is done.
// After reset and after every FLUSH or end item the dictionary is cleared one
// entry a cycle, with s_ready low until every entry is cleared.
// ---------------------------------------------------------------------------
// LZW variable width encoder
// Iterative dictionary probe sequencer around one single-port RAM.
// ---------------------------------------------------------------------------
`default_nettype none
module lzw_variable_width_encoder #(
    parameter int TABLE_ENTRIES = lzwve_pkg::TABLE_ENTRIES_DEF,
    parameter int MAX_CODE_BITS = lzwve_pkg::MAX_CODE_BITS_DEF
) (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic                             s_valid,
    output logic                                  s_ready,
    input  wire logic                             s_op,
    input  wire logic [7:0]                       s_data_byte,
    output logic                                  m_valid,
    input  wire logic                             m_ready,
    output logic [lzwve_pkg::CODE_BITS-1:0]       m_code,
    output logic [lzwve_pkg::WIDTH_BITS-1:0]      m_code_width,
    output logic                                  m_last
);
    import lzwve_pkg::*;

    localparam int AW = $clog2(TABLE_ENTRIES);
    localparam int EW = 1 + 2 * CODE_BITS + 8;
    localparam logic [16:0] TE = 17'(TABLE_ENTRIES);
    localparam logic [16:0] CODE_LIMIT = 17'((1 << MAX_CODE_BITS) - 1);

    state_t state_reg, state_next;
    logic [AW-1:0] idx_reg, step_reg, cnt_reg;
    logic [16:0] probes_reg;
    logic [CODE_BITS-1:0] prefix_reg;
    logic have_reg, op_reg, flush_reg;
    logic [7:0] byte_reg;
    logic [16:0] nfc_reg;
    logic [WIDTH_BITS-1:0] width_reg;
    logic [15:0] thr_reg;
    logic found_reg;
    logic [CODE_BITS-1:0] r0_code_reg, r1_code_reg;
    logic two_reg;

    logic we;
    logic [AW-1:0] addr;
    logic [EW-1:0] wdata, rdata;
    logic r_used;
    logic [CODE_BITS-1:0] r_code, r_parent;
    logic [7:0] r_byte;
    logic [16:0] hash;
    logic [17:0] sub;

    assign {r_used, r_code, r_parent, r_byte} = rdata;
    assign hash = 17'({byte_reg, {(MAX_CODE_BITS-8){1'b0}}}) ^ 17'(prefix_reg);
    assign sub = {1'b0, hash} - {1'b0, TE};

    always_comb begin
        we    = 1'b0;
        addr  = idx_reg;
        wdata = {1'b1, nfc_reg[CODE_BITS-1:0], prefix_reg, byte_reg};
        if (state_reg == ST_CLEAR) begin
            we    = 1'b1;
            addr  = cnt_reg;
            wdata = '0;
        end else if (state_reg == ST_WRITE) begin
            we = found_reg;
        end
    end

    lzwve_ram #(.WIDTH(EW), .DEPTH(TABLE_ENTRIES)) u_dict (
        .aclk (aclk), .we (we), .addr (addr), .wdata (wdata), .rdata (rdata)
    );

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = (state_reg == ST_EMIT0) || (state_reg == ST_EMIT1);
    assign m_code  = (state_reg == ST_EMIT1) ? r1_code_reg : r0_code_reg;
    assign m_code_width = width_reg;
    assign m_last  = (state_reg == ST_EMIT1) || !two_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_CLEAR;
            cnt_reg    <= '0;
            prefix_reg <= CODE_END;
            have_reg   <= 1'b0;
            nfc_reg    <= 17'(CODE_FIRST);
            width_reg  <= WIDTH_START;
            thr_reg    <= BUMP_START;
            flush_reg  <= 1'b0;
        end else begin
            unique case (state_reg)
                ST_CLEAR: begin
                    cnt_reg <= cnt_reg + 1'b1;
                    if (32'(cnt_reg) == TABLE_ENTRIES - 1) begin
                        cnt_reg   <= '0;
                        state_reg <= ST_IDLE;
                    end
                end
                ST_IDLE: begin
                    if (s_valid) begin
                        op_reg   <= s_op;
                        byte_reg <= s_data_byte;
                        if (s_op) begin
                            r0_code_reg <= prefix_reg;
                            r1_code_reg <= CODE_END;
                            two_reg     <= 1'b1;
                            state_reg   <= ST_EMIT0;
                        end else if (!have_reg) begin
                            prefix_reg <= 15'(s_data_byte);
                            have_reg   <= 1'b1;
                        end else begin
                            state_reg <= ST_HASH;
                        end
                    end
                end
                ST_HASH: begin
                    // Fold the hash once: it stays below twice the table size
                    idx_reg    <= sub[17] ? AW'(hash) : AW'(sub[16:0]);
                    probes_reg <= '0;
                    state_reg  <= ST_STEP;
                end
                ST_STEP: begin
                    if (probes_reg == 17'd0) begin
                        step_reg <= (idx_reg == '0) ? AW'(1) : AW'(TE - 17'(idx_reg));
                    end
                    state_reg <= ST_READ;
                end
                ST_READ: state_reg <= ST_CHECK;
                ST_CHECK: begin
                    if (r_used && r_parent == prefix_reg && r_byte == byte_reg) begin
                        prefix_reg <= r_code;
                        state_reg  <= ST_IDLE;
                    end else if (!r_used || probes_reg == TE - 17'd1) begin
                        found_reg <= !r_used;
                        state_reg <= ST_WRITE;
                    end else begin
                        probes_reg <= probes_reg + 17'd1;
                        idx_reg <= (idx_reg >= step_reg) ? AW'(idx_reg - step_reg)
                                 : AW'(17'(idx_reg) + TE - 17'(step_reg));
                        state_reg <= ST_STEP;
                    end
                end
                ST_WRITE: begin
                    r0_code_reg <= prefix_reg;
                    prefix_reg  <= 15'(byte_reg);
                    nfc_reg     <= nfc_reg + 17'd1;
                    two_reg     <= 1'b0;
                    if (nfc_reg + 17'd1 > CODE_LIMIT) begin
                        r1_code_reg <= CODE_FLUSH;
                        two_reg     <= 1'b1;
                        flush_reg   <= 1'b1;
                    end else if (nfc_reg + 17'd1 > 17'(thr_reg)) begin
                        r1_code_reg <= CODE_BUMP;
                        two_reg     <= 1'b1;
                    end
                    state_reg <= ST_EMIT0;
                end
                ST_EMIT0: begin
                    if (m_ready) begin
                        state_reg <= two_reg ? ST_EMIT1 : ST_IDLE;
                    end
                end
                ST_EMIT1: begin
                    if (m_ready) begin
                        state_reg <= ST_IDLE;
                        if (op_reg || flush_reg) begin
                            // restart dictionary
                            nfc_reg   <= 17'(CODE_FIRST);
                            width_reg <= WIDTH_START;
                            thr_reg   <= BUMP_START;
                            flush_reg <= 1'b0;
                            state_reg <= ST_CLEAR;
                            if (op_reg) begin
                                prefix_reg <= CODE_END;
                                have_reg   <= 1'b0;
                            end
                        end else begin
                            width_reg <= width_reg + 1'b1;
                            thr_reg   <= {thr_reg[14:0], 1'b1};
                        end
                    end
                end
                default: state_reg <= ST_CLEAR;
            endcase
        end
    end
endmodule
`default_nettype wire

>>> hdl/lzwve_ram.sv
// ---------------------------------------------------------------------------
// LZW encoder RAM
// Generic single-port RAM with registered read.
// ---------------------------------------------------------------------------
`default_nettype none
module lzwve_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] addr,
    input  wire logic [WIDTH-1:0]         wdata,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end
endmodule
`default_nettype wire

>>> hdl/lzwve_checker.sv
// ---------------------------------------------------------------------------
// LZW encoder checker
// Port-level assertions, bound to the top level.
// ---------------------------------------------------------------------------
`default_nettype none
module lzwve_checker (
    input wire logic                             aclk,
    input wire logic                             aresetn,
    input wire logic                             s_valid,
    input wire logic                             s_ready,
    input wire logic                             m_valid,
    input wire logic                             m_ready,
    input wire logic [lzwve_pkg::CODE_BITS-1:0]  m_code,
    input wire logic [lzwve_pkg::WIDTH_BITS-1:0] m_code_width,
    input wire logic                             m_last
);
    import lzwve_pkg::*;

    a_width: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_code_width >= 4'd9 && m_code_width <= 4'd15))
        else $error("code width out of range");
    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_ready && m_valid)) else $error("input taken while result pending");
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_code))
        else $error("result dropped");
    a_end_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_code == CODE_END && !m_last |=> m_valid)
        else $error("end without pair");
    a_in_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && !s_ready |=> s_valid)
        else $error("input withdrawn before transfer");
endmodule

bind lzw_variable_width_encoder lzwve_checker u_chk (
    .aclk(aclk), .aresetn(aresetn), .s_valid(s_valid), .s_ready(s_ready),
    .m_valid(m_valid), .m_ready(m_ready), .m_code(m_code),
    .m_code_width(m_code_width), .m_last(m_last)
);
`default_nettype wire

>>> verif/tb_lzw_variable_width_encoder.sv
// ---------------------------------------------------------------------------
// LZW variable width encoder testbench
// Drives byte streams and end items through the encoder with random gaps on
// both channels. Predicts every emitted code and width from a local copy of
// the hash dictionary and compares each result transfer in order.
// ---------------------------------------------------------------------------
`default_nettype none
module tb_lzw_variable_width_encoder;
    import lzwve_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int TE        = TABLE_ENTRIES_DEF;
    localparam int CODE_TOP  = (1 << MAX_CODE_BITS_DEF) - 1;
    localparam int STALL_MAX = 200000;

    localparam logic OP_DATA = 1'b0;
    localparam logic OP_END  = 1'b1;

    typedef struct packed {
        logic       op;
        logic [7:0] data;
    } byte_item_t;

    typedef struct packed {
        logic [CODE_BITS-1:0]  code;
        logic [WIDTH_BITS-1:0] width;
        logic                  last;
    } code_word_t;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  s_valid = 1'b0;
    logic                  s_ready;
    logic                  s_op = 1'b0;
    logic [7:0]            s_data_byte = 8'd0;
    logic                  m_valid;
    logic                  m_ready = 1'b0;
    logic [CODE_BITS-1:0]  m_code;
    logic [WIDTH_BITS-1:0] m_code_width;
    logic                  m_last;

    lzw_variable_width_encoder dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_op(s_op), .s_data_byte(s_data_byte),
        .m_valid(m_valid), .m_ready(m_ready), .m_code(m_code),
        .m_code_width(m_code_width), .m_last(m_last)
    );

    always #10 aclk = ~aclk;

    // dictionary mirror
    bit          dict_used [TE];
    logic [14:0] dict_code [TE];
    logic [14:0] dict_parent [TE];
    logic [7:0]  dict_byte [TE];
    int unsigned prefix;
    bit          prefix_valid;
    int unsigned free_code;
    int unsigned cur_width;
    int unsigned bump_at;

    byte_item_t  pending_bytes[$];
    code_word_t  expected_codes[$];
    int          errors = 0;
    int          n_bytes = 0, n_ends = 0, n_codes = 0, n_bumps = 0, n_flushes = 0;

    task automatic clear_dictionary();
        for (int i = 0; i < TE; i++) dict_used[i] = 1'b0;
        free_code = CODE_FIRST;
        cur_width = WIDTH_START;
        bump_at   = BUMP_START;
    endtask

    task automatic restart_stream();
        clear_dictionary();
        prefix       = CODE_END;
        prefix_valid = 1'b0;
    endtask

    function automatic code_word_t mk_word(int unsigned c, int unsigned w, bit l);
        code_word_t r;
        r.code  = c[14:0];
        r.width = w[3:0];
        r.last  = l;
        return r;
    endfunction

    task automatic encode_miss_or_hit(byte_item_t it);
        int unsigned idx, step, slot, n, old_prefix;
        bit          found;
        old_prefix = prefix;
        idx   = ((int'(it.data) << 7) ^ prefix) % TE;
        step  = (idx == 0) ? 1 : TE - idx;
        found = 1'b0;
        slot  = 0;
        for (n = 0; n < TE && !found; n++) begin
            if (!dict_used[idx] || (dict_parent[idx] == prefix[14:0] && dict_byte[idx] == it.data)) begin
                found = 1'b1;
                slot  = idx;
            end else begin
                idx = (idx >= step) ? idx - step : idx + TE - step;
            end
        end
        if (found && dict_used[slot]) begin
            prefix = dict_code[slot];
            return;
        end
        if (found) begin
            dict_used[slot]   = 1'b1;
            dict_code[slot]   = free_code[14:0];
            dict_parent[slot] = old_prefix[14:0];
            dict_byte[slot]   = it.data;
        end
        free_code++;
        prefix = it.data;
        if (free_code > CODE_TOP) begin
            expected_codes.push_back(mk_word(old_prefix, cur_width, 1'b0));
            expected_codes.push_back(mk_word(CODE_FLUSH, cur_width, 1'b1));
            n_flushes++;
            clear_dictionary();
        end else if (free_code > bump_at) begin
            expected_codes.push_back(mk_word(old_prefix, cur_width, 1'b0));
            expected_codes.push_back(mk_word(CODE_BUMP, cur_width, 1'b1));
            n_bumps++;
            cur_width++;
            bump_at = ((bump_at << 1) | 1) & 16'hFFFF;
        end else begin
            expected_codes.push_back(mk_word(old_prefix, cur_width, 1'b1));
        end
    endtask

    task automatic encode_item(byte_item_t it);
        if (it.op == OP_END) begin
            expected_codes.push_back(mk_word(prefix, cur_width, 1'b0));
            expected_codes.push_back(mk_word(CODE_END, cur_width, 1'b1));
            restart_stream();
            return;
        end
        if (!prefix_valid) begin
            prefix       = it.data;
            prefix_valid = 1'b1;
            return;
        end
        encode_miss_or_hit(it);
    endtask

    function automatic byte_item_t mk_item(logic op, logic [7:0] d);
        byte_item_t r;
        r.op   = op;
        r.data = d;
        return r;
    endfunction

    // driver
    int drv_gap = 0;
    bit drv_burst = 1'b0;
    always @(posedge aclk) begin
        byte_item_t nxt;
        logic       nv;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            nv = s_valid;
            if (s_valid && s_ready) begin
                encode_item(mk_item(s_op, s_data_byte));
                if (s_op == OP_END) n_ends++; else n_bytes++;
                nv = 1'b0;
            end
            if (!nv) begin
                if (drv_gap > 0) begin
                    drv_gap--;
                end else if (pending_bytes.size() > 0) begin
                    nxt = pending_bytes.pop_front();
                    s_op        <= nxt.op;
                    s_data_byte <= nxt.data;
                    nv = 1'b1;
                    if ($urandom_range(0, 49) == 0) drv_burst = ~drv_burst;
                    drv_gap = drv_burst ? 0 : $urandom_range(0, 3);
                end
            end
            s_valid <= nv;
        end
    end

    // monitor
    int mon_gap = 0;
    bit mon_burst = 1'b0;
    always @(posedge aclk) begin
        code_word_t exp_w;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                n_codes++;
                if (expected_codes.size() == 0) begin
                    errors++;
                    $display("%0t: unexpected code: expected none, actual code %0d width %0d last %0d",
                             $time, m_code, m_code_width, m_last);
                end else begin
                    exp_w = expected_codes.pop_front();
                    if (m_code !== exp_w.code) begin
                        errors++;
                        $display("%0t: code mismatch: expected %0d actual %0d",
                                 $time, exp_w.code, m_code);
                    end
                    if (m_code_width !== exp_w.width) begin
                        errors++;
                        $display("%0t: width mismatch: expected %0d actual %0d",
                                 $time, exp_w.width, m_code_width);
                    end
                    if (m_last !== exp_w.last) begin
                        errors++;
                        $display("%0t: last mismatch: expected %0d actual %0d",
                                 $time, exp_w.last, m_last);
                    end
                end
                if ($urandom_range(0, 49) == 0) mon_burst = ~mon_burst;
                mon_gap = mon_burst ? 0 : $urandom_range(0, 3);
            end
            // hold ready low for the drawn gap, then raise it
            if (mon_gap > 0) begin
                mon_gap--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // watchdog
    int stall_cnt = 0;
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            stall_cnt <= 0;
        end else if (stall_cnt >= STALL_MAX) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end else begin
            stall_cnt <= stall_cnt + 1;
        end
    end

    task automatic add_stream(int len, int mode);
        logic [7:0] base;
        base = 8'($urandom_range(0, 255));
        for (int i = 0; i < len; i++) begin
            case (mode)
                0: pending_bytes.push_back(mk_item(OP_DATA, 8'($urandom_range(0, 255))));
                1: pending_bytes.push_back(mk_item(OP_DATA, base ^ 8'($urandom_range(0, 3))));
                default: pending_bytes.push_back(mk_item(OP_DATA,
                                                         base ^ 8'($urandom_range(0, 15))));
            endcase
        end
        pending_bytes.push_back(mk_item(OP_END, 8'($urandom_range(0, 255))));
    endtask

    initial begin
        int total;
        restart_stream();
        // end with no data, single byte, extremes with repeats for hits
        pending_bytes.push_back(mk_item(OP_END, 8'hFF));
        pending_bytes.push_back(mk_item(OP_DATA, 8'h00));
        pending_bytes.push_back(mk_item(OP_END, 8'h00));
        for (int i = 0; i < 4; i++) begin
            pending_bytes.push_back(mk_item(OP_DATA, 8'h00));
            pending_bytes.push_back(mk_item(OP_DATA, 8'hFF));
        end
        pending_bytes.push_back(mk_item(OP_DATA, 8'hAA));
        pending_bytes.push_back(mk_item(OP_DATA, 8'h55));
        pending_bytes.push_back(mk_item(OP_DATA, 8'hAA));
        pending_bytes.push_back(mk_item(OP_DATA, 8'h55));
        pending_bytes.push_back(mk_item(OP_DATA, 8'hAA));
        pending_bytes.push_back(mk_item(OP_END, 8'h55));
        total = 17;
        // few long streams: each end costs a full dictionary clear
        while (total < 950) begin
            int len;
            len = $urandom_range(120, 320);
            add_stream(len, $urandom_range(0, 2));
            total += len + 1;
        end

        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        // sample between edges so the driver and monitor have settled
        do @(negedge aclk);
        while (pending_bytes.size() != 0 || s_valid || expected_codes.size() != 0);
        repeat (60) @(posedge aclk);
        $display("Covered %0d data bytes and %0d end items, %0d codes checked.",
                 n_bytes, n_ends, n_codes);
        $display("Widening steps seen: %0d, dictionary flushes seen: %0d.", n_bumps, n_flushes);
        if (errors == 0 && expected_codes.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end
endmodule
`default_nettype wire

>>> files.f
hdl/lzwve_pkg.sv
hdl/lzwve_ram.sv
hdl/lzw_variable_width_encoder.sv
hdl/lzwve_checker.sv
verif/tb_lzw_variable_width_encoder.sv
